// ----- hw/rtl/gne_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gne_pkg
// Shared constants, codes and the command/status bundles of the gate netlist
// evaluator.
// ----------------------------------------------------------------------------
package gne_pkg;

  localparam int MAX_GATES   = 128;
  localparam int MAX_SIGNALS = 256;
  localparam int PORT_DEPTH  = 1024;
  localparam int MAX_SELECT  = 4;
  localparam int MAX_INPUTS  = 16;
  localparam int MAX_OUTPUTS = 16;

  localparam int GIDX_W = 7;
  localparam int GCNT_W = 8;
  localparam int SIG_W  = 8;
  localparam int PADR_W = 10;
  localparam int OFF_W  = 5;
  localparam int CNT_W  = 5;
  localparam int SEL_W  = 4;
  localparam int ENT_W  = 17;

  localparam logic [1:0] OP_GATE = 2'd0;
  localparam logic [1:0] OP_PORT = 2'd1;
  localparam logic [1:0] OP_EVAL = 2'd2;

  localparam logic [3:0] KIND_PASS = 4'd0;
  localparam logic [3:0] KIND_NOT  = 4'd1;
  localparam logic [3:0] KIND_AND  = 4'd2;
  localparam logic [3:0] KIND_OR   = 4'd3;
  localparam logic [3:0] KIND_NAND = 4'd4;
  localparam logic [3:0] KIND_NOR  = 4'd5;
  localparam logic [3:0] KIND_XOR  = 4'd6;
  localparam logic [3:0] KIND_DEC  = 4'd7;
  localparam logic [3:0] KIND_MUX  = 4'd8;

  // port access steps of one gate
  localparam logic [2:0] STEP_A    = 3'd0;
  localparam logic [2:0] STEP_B    = 3'd1;
  localparam logic [2:0] STEP_WR   = 3'd2;
  localparam logic [2:0] STEP_CLR  = 3'd3;
  localparam logic [2:0] STEP_SEL  = 3'd4;
  localparam logic [2:0] STEP_SET  = 3'd5;
  localparam logic [2:0] STEP_MUXA = 3'd6;

  localparam logic [1:0] REG_GATES   = 2'd0;
  localparam logic [1:0] REG_INPUTS  = 2'd1;
  localparam logic [1:0] REG_OUTPUTS = 2'd2;

  typedef struct packed {
    logic       wr_gate;
    logic       wr_port;
    logic       start;
    logic       g_rd;
    logic       g_latch;
    logic       g_inc;
    logic       p_rd;
    logic       s_rd;
    logic       s_wr;
    logic       s_take;
    logic       i_clr;
    logic       i_inc;
    logic       o_rd;
    logic       o_take;
    logic       o_load;
    logic [2:0] step;
  } gne_cmd_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [2:0]       k;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] i;
    logic             last_gate;
    logic             no_gates;
    logic             last_out;
    logic             no_outs;
    logic             out_busy;
  } gne_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/gne_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gne_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gne_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/gne_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gne_ctrl
// Sequencer: walks the gate table, steps through each gate's port accesses
// and collects the outputs.
// ----------------------------------------------------------------------------
module gne_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        operation_i,
  input  wire gne_pkg::gne_stat_t stat_i,
  output gne_pkg::gne_cmd_t      cmd_o
);
  import gne_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_GFETCH = 4'd1;
  localparam logic [3:0] S_GDEC   = 4'd2;
  localparam logic [3:0] S_GSTART = 4'd3;
  localparam logic [3:0] S_PRD    = 4'd4;
  localparam logic [3:0] S_PWAIT  = 4'd5;
  localparam logic [3:0] S_SRES   = 4'd6;
  localparam logic [3:0] S_ORD    = 4'd7;
  localparam logic [3:0] S_ORES   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       i_last_n, i_last_k;

  assign i_last_n = ({1'b0, stat_i.i} + 1'b1) == {1'b0, stat_i.n};
  assign i_last_k = ({1'b0, stat_i.i} + 1'b1) == (CNT_W+1)'(stat_i.k);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (operation_i)
            OP_GATE: cmd_o.wr_gate = 1'b1;
            OP_PORT: cmd_o.wr_port = 1'b1;
            OP_EVAL: begin
              cmd_o.start = 1'b1;
              if (!stat_i.no_gates) begin
                state_d = S_GFETCH;
              end else if (stat_i.no_outs) begin
                state_d = S_DONE;
              end else begin
                state_d = S_ORD;
              end
            end
            default: ;
          endcase
        end
      end
      S_GFETCH: begin
        cmd_o.g_rd = 1'b1;
        state_d    = S_GDEC;
      end
      S_GDEC: begin
        cmd_o.g_latch = 1'b1;
        cmd_o.i_clr   = 1'b1;
        state_d       = S_GSTART;
      end
      S_GSTART: begin
        state_d = S_PRD;
        case (stat_i.kind)
          KIND_PASS, KIND_NOT, KIND_AND, KIND_OR,
          KIND_NAND, KIND_NOR, KIND_XOR: step_d = STEP_A;
          KIND_DEC: step_d = STEP_CLR;
          KIND_MUX: step_d = (stat_i.k != 3'd0) ? STEP_SEL : STEP_MUXA;
          default: begin
            // unknown kinds leave the signals alone
            cmd_o.g_inc = 1'b1;
            cmd_o.i_clr = 1'b1;
            if (!stat_i.last_gate) state_d = S_GFETCH;
            else if (stat_i.no_outs) state_d = S_DONE;
            else state_d = S_ORD;
          end
        endcase
      end
      S_PRD: begin
        cmd_o.p_rd = 1'b1;
        state_d    = S_PWAIT;
      end
      S_PWAIT: begin
        case (step_q)
          STEP_WR, STEP_SET: begin
            cmd_o.s_wr  = 1'b1;
            cmd_o.g_inc = 1'b1;
            cmd_o.i_clr = 1'b1;
            if (!stat_i.last_gate) state_d = S_GFETCH;
            else if (stat_i.no_outs) state_d = S_DONE;
            else state_d = S_ORD;
          end
          STEP_CLR: begin
            cmd_o.s_wr = 1'b1;
            state_d    = S_PRD;
            if (i_last_n) begin
              cmd_o.i_clr = 1'b1;
              step_d      = (stat_i.k != 3'd0) ? STEP_SEL : STEP_SET;
            end else begin
              cmd_o.i_inc = 1'b1;
            end
          end
          default: begin
            cmd_o.s_rd = 1'b1;
            state_d    = S_SRES;
          end
        endcase
      end
      S_SRES: begin
        cmd_o.s_take = 1'b1;
        state_d      = S_PRD;
        case (step_q)
          STEP_A: step_d = (stat_i.kind == KIND_PASS || stat_i.kind == KIND_NOT) ?
                           STEP_WR : STEP_B;
          STEP_SEL: begin
            if (i_last_k) begin
              cmd_o.i_clr = 1'b1;
              step_d      = (stat_i.kind == KIND_DEC) ? STEP_SET : STEP_MUXA;
            end else begin
              cmd_o.i_inc = 1'b1;
            end
          end
          default: step_d = STEP_WR;
        endcase
      end
      S_ORD: begin
        cmd_o.o_rd = 1'b1;
        state_d    = S_ORES;
      end
      S_ORES: begin
        cmd_o.o_take = 1'b1;
        if (stat_i.last_out) begin
          state_d = S_DONE;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_ORD;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.o_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= STEP_A;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/gne_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gne_dp
// Datapath: gate table, port list and signal memories, signal valid bits,
// gate operands and the output register.
// ----------------------------------------------------------------------------
module gne_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire gne_pkg::gne_cmd_t          cmd_i,
  output gne_pkg::gne_stat_t              stat_o,
  input  wire logic [gne_pkg::GCNT_W-1:0] gate_count_i,
  input  wire logic [4:0]                 input_count_i,
  input  wire logic [4:0]                 output_count_i,
  input  wire logic [gne_pkg::GIDX_W-1:0] gate_index_i,
  input  wire logic [3:0]                 gate_kind_i,
  input  wire logic [2:0]                 select_width_i,
  input  wire logic [gne_pkg::PADR_W-1:0] port_base_i,
  input  wire logic [gne_pkg::PADR_W-1:0] port_address_i,
  input  wire logic [gne_pkg::SIG_W-1:0]  port_signal_i,
  input  wire logic [15:0]                input_vector_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [15:0]                     output_vector_o
);
  import gne_pkg::*;

  logic [GCNT_W-1:0]      g_q, ng;
  logic [4:0]             ni, no;
  logic [3:0]             kind_q;
  logic [2:0]             k_q;
  logic [PADR_W-1:0]      base_q;
  logic [CNT_W-1:0]       i_q, n;
  logic [SEL_W-1:0]       sel_q;
  logic                   a_q, b_q;
  logic [15:0]            vec_q, ores_q;
  logic [MAX_SIGNALS-1:0] valid_q;
  logic                   sv_valid_q, sv_dflt_q, sv_val;
  logic [ENT_W-1:0]       g_rdata;
  logic [SIG_W-1:0]       p_rdata, sidx, vbit;
  logic [OFF_W-1:0]       off;
  logic                   s_rdata, wval, dflt;

  assign ng = (gate_count_i > GCNT_W'(MAX_GATES)) ? GCNT_W'(MAX_GATES) : gate_count_i;
  assign ni = (input_count_i > 5'(MAX_INPUTS)) ? 5'(MAX_INPUTS) : input_count_i;
  assign no = (output_count_i > 5'(MAX_OUTPUTS)) ? 5'(MAX_OUTPUTS) : output_count_i;
  assign n  = CNT_W'(1) << k_q;

  gne_ram #(.Width(ENT_W), .Depth(MAX_GATES)) u_gate_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_gate),
    .waddr_i (gate_index_i),
    .wdata_i ({gate_kind_i, select_width_i, port_base_i}),
    .re_i    (cmd_i.g_rd),
    .raddr_i (g_q[GIDX_W-1:0]),
    .rdata_o (g_rdata)
  );

  always_comb begin
    case (cmd_i.step)
      STEP_A:    off = '0;
      STEP_B:    off = OFF_W'(1);
      STEP_WR: begin
        if (kind_q == KIND_PASS || kind_q == KIND_NOT) off = OFF_W'(1);
        else if (kind_q == KIND_MUX) off = n + OFF_W'(k_q);
        else off = OFF_W'(2);
      end
      STEP_CLR:  off = OFF_W'(k_q) + i_q;
      STEP_SEL:  off = (kind_q == KIND_DEC) ? i_q : n + i_q;
      STEP_SET:  off = OFF_W'(k_q) + OFF_W'(sel_q);
      STEP_MUXA: off = OFF_W'(sel_q);
      default:   off = '0;
    endcase
  end

  gne_ram #(.Width(SIG_W), .Depth(PORT_DEPTH)) u_port_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_port),
    .waddr_i (port_address_i),
    .wdata_i (port_signal_i),
    .re_i    (cmd_i.p_rd),
    .raddr_i (base_q + PADR_W'(off)),
    .rdata_o (p_rdata)
  );

  always_comb begin
    case (cmd_i.step)
      STEP_CLR: wval = 1'b0;
      STEP_SET: wval = 1'b1;
      default: begin
        case (kind_q)
          KIND_NOT:  wval = ~a_q;
          KIND_AND:  wval = a_q & b_q;
          KIND_OR:   wval = a_q | b_q;
          KIND_NAND: wval = ~(a_q & b_q);
          KIND_NOR:  wval = ~(a_q | b_q);
          KIND_XOR:  wval = a_q ^ b_q;
          default:   wval = a_q;
        endcase
      end
    endcase
  end

  // signal being read: port entry, or next primary output
  assign sidx = cmd_i.o_rd ? (SIG_W'(2) + SIG_W'(ni) + SIG_W'(i_q)) : p_rdata;
  // untouched signals: constant one, primary input or zero
  assign vbit = SIG_W'(ni) + SIG_W'(1) - sidx;
  always_comb begin
    if (sidx == SIG_W'(1)) dflt = 1'b1;
    else if (sidx >= SIG_W'(2) && sidx < SIG_W'(2) + SIG_W'(ni)) dflt = vec_q[vbit[3:0]];
    else dflt = 1'b0;
  end

  gne_ram #(.Width(1), .Depth(MAX_SIGNALS)) u_sig_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.s_wr),
    .waddr_i (p_rdata),
    .wdata_i (wval),
    .re_i    (cmd_i.s_rd | cmd_i.o_rd),
    .raddr_i (sidx),
    .rdata_o (s_rdata)
  );

  assign sv_val = sv_valid_q ? s_rdata : sv_dflt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) vec_q <= input_vector_i;
    if (cmd_i.g_latch) begin
      base_q <= g_rdata[PADR_W-1:0];
      k_q    <= (g_rdata[PADR_W+2:PADR_W] > 3'(MAX_SELECT)) ? 3'(MAX_SELECT)
                                                           : g_rdata[PADR_W+2:PADR_W];
      kind_q <= g_rdata[ENT_W-1:PADR_W+3];
      sel_q  <= '0;
    end
    if (cmd_i.s_rd || cmd_i.o_rd) begin
      sv_valid_q <= valid_q[sidx];
      sv_dflt_q  <= dflt;
    end
    if (cmd_i.s_take) begin
      case (cmd_i.step)
        STEP_B:   b_q   <= sv_val;
        STEP_SEL: sel_q <= {sel_q[SEL_W-2:0], sv_val};
        default:  a_q   <= sv_val;
      endcase
    end
    if (cmd_i.start) ores_q <= '0;
    else if (cmd_i.o_take) ores_q <= {ores_q[14:0], sv_val};
    if (cmd_i.o_load) output_vector_o <= ores_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q         <= '0;
      i_q         <= '0;
      valid_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.start) g_q <= '0;
      else if (cmd_i.g_inc) g_q <= g_q + GCNT_W'(1);
      if (cmd_i.start || cmd_i.i_clr) i_q <= '0;
      else if (cmd_i.i_inc) i_q <= i_q + CNT_W'(1);
      if (cmd_i.start) valid_q <= '0;
      else if (cmd_i.s_wr) valid_q[p_rdata] <= 1'b1;
      if (cmd_i.o_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  assign stat_o.kind      = kind_q;
  assign stat_o.k         = k_q;
  assign stat_o.n         = n;
  assign stat_o.i         = i_q;
  assign stat_o.last_gate = ({1'b0, g_q} + 1'b1) >= {1'b0, ng};
  assign stat_o.no_gates  = (ng == '0);
  assign stat_o.last_out  = ({1'b0, i_q} + 1'b1) == {1'b0, no};
  assign stat_o.no_outs   = (no == '0);
  assign stat_o.out_busy  = out_valid_o & ~out_ready_i;

endmodule
`default_nettype wire

// ----- hw/rtl/gate_netlist_evaluator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gate_netlist_evaluator_core
// Gate-level netlist evaluator with APB configuration and item channels.
// ----------------------------------------------------------------------------
// Items with operation 0 or 1 write one gate table or port list entry. An
// evaluate item restarts from fresh signals and walks the gate table one gate
// at a time through a single port list read port and a single signal memory
// read port: each gate is fetched, decoded and started, each signal read goes
// through port read, port wait and signal result, each signal write (for
// decoders each output cleared) through port read and port wait; then each
// primary output is read and taken. The result sits in an output register, so
// the next item is taken while it waits.
module gate_netlist_evaluator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [6:0]  gate_index_i,
  input  wire logic [3:0]  gate_kind_i,
  input  wire logic [2:0]  select_width_i,
  input  wire logic [9:0]  port_base_i,
  input  wire logic [9:0]  port_address_i,
  input  wire logic [7:0]  port_signal_i,
  input  wire logic [15:0] input_vector_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      output_vector_o
);
  import gne_pkg::*;

  logic [GCNT_W-1:0] gate_count_q;
  logic [4:0]        input_count_q, output_count_q;
  logic              wr_en;
  gne_cmd_t          cmd;
  gne_stat_t         stat;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_count_q   <= '0;
      input_count_q  <= 5'd1;
      output_count_q <= 5'd1;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_GATES:   gate_count_q   <= pwdata[GCNT_W-1:0];
        REG_INPUTS:  input_count_q  <= pwdata[4:0];
        REG_OUTPUTS: output_count_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GATES:   prdata = 32'(gate_count_q);
      REG_INPUTS:  prdata = 32'(input_count_q);
      REG_OUTPUTS: prdata = 32'(output_count_q);
      default:     prdata = '0;
    endcase
  end

  gne_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gne_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .gate_count_i    (gate_count_q),
    .input_count_i   (input_count_q),
    .output_count_i  (output_count_q),
    .gate_index_i    (gate_index_i),
    .gate_kind_i     (gate_kind_i),
    .select_width_i  (select_width_i),
    .port_base_i     (port_base_i),
    .port_address_i  (port_address_i),
    .port_signal_i   (port_signal_i),
    .input_vector_i  (input_vector_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .output_vector_o (output_vector_o)
  );

endmodule
`default_nettype wire
